@@ sv/qra_pkg.sv @@
// ----------------------------------------------------------------------------
// qra_pkg
// Shared types, constants and lookup functions of the alphanumeric encoder.
// ----------------------------------------------------------------------------
package qra_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 1'b1;

  // field widths
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned VALUE_W    = 6;
  localparam int unsigned PAIR_BITS  = 11;
  localparam int unsigned MODE_BITS  = 4;
  localparam int unsigned TERM_BITS  = 4;
  localparam int unsigned CAP_TBL_W  = 9;

  localparam logic [MODE_BITS-1:0] MODE_ALNUM   = 4'b0010;
  localparam logic [7:0]           PAD_FIRST    = 8'hEC;
  localparam logic [7:0]           PAD_SECOND   = 8'h11;
  localparam logic [PAIR_BITS-1:0] CHARSET_SIZE = 11'd45;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_HDR,
    OP_CHAR,
    OP_ODD,
    OP_TERM,
    OP_ZFILL,
    OP_PAD,
    OP_FLUSH,
    OP_END
  } qra_op_e;

  typedef struct packed {
    qra_op_e op;
    logic    last;
  } qra_cmd_t;

  typedef struct packed {
    logic room;        // fewer than eight bits in the accumulator
    logic hold_empty;
    logic held_valid;
    logic pad_fits;
  } qra_stat_t;

  // alphanumeric character value, unmapped bytes give zero
  function automatic logic [VALUE_W-1:0] char_value(input logic [CODE_W-1:0] ch);
    logic [VALUE_W-1:0] v;
    v = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = VALUE_W'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = VALUE_W'(ch - 8'h41 + 8'd10);
    end else begin
      unique case (ch)
        8'h20:   v = 6'd36;
        8'h24:   v = 6'd37;
        8'h25:   v = 6'd38;
        8'h2A:   v = 6'd39;
        8'h2B:   v = 6'd40;
        8'h2D:   v = 6'd41;
        8'h2E:   v = 6'd42;
        8'h2F:   v = 6'd43;
        8'h3A:   v = 6'd44;
        default: v = 6'd0;
      endcase
    end
    return v;
  endfunction

  // data capacity in bits, row is version 1 or 2, col is L/M/Q/H
  function automatic logic [CAP_TBL_W-1:0] cap_lookup(input logic row,
                                                      input logic [1:0] col);
    logic [CAP_TBL_W-1:0] c;
    unique case ({row, col})
      3'b000:  c = 9'd152;
      3'b001:  c = 9'd128;
      3'b010:  c = 9'd104;
      3'b011:  c = 9'd72;
      3'b100:  c = 9'd272;
      3'b101:  c = 9'd224;
      3'b110:  c = 9'd176;
      default: c = 9'd128;
    endcase
    return c;
  endfunction

endpackage

@@ sv/qra_ctrl.sv @@
// ----------------------------------------------------------------------------
// qra_ctrl
// Sequencer: steps one message item through header, data and final padding.
// ----------------------------------------------------------------------------
module qra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              has_char_i,
  input  logic              last_i,
  input  qra_pkg::qra_stat_t stat_i,
  output qra_pkg::qra_cmd_t  cmd_o
);
  import qra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_CHR,
    S_ODD,
    S_TERM,
    S_ZFILL,
    S_PAD,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   in_msg_q, in_msg_d;
  logic   has_char_q, has_char_d;
  logic   last_q, last_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o      = '{op: OP_NONE, last: last_q};
    state_d    = state_q;
    in_msg_d   = in_msg_q;
    has_char_d = has_char_q;
    last_d     = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op   = OP_LOAD;
          has_char_d = has_char_i;
          last_d     = last_i;
          state_d    = in_msg_q ? S_CHR : S_HDR;
        end
      end
      S_HDR: begin
        if (stat_i.room) begin
          cmd_o.op = OP_HDR;
          in_msg_d = 1'b1;
          state_d  = S_CHR;
        end
      end
      S_CHR: begin
        if (!has_char_q) begin
          state_d = last_q ? S_ODD : S_FLUSH;
        end else if (stat_i.room) begin
          cmd_o.op = OP_CHAR;
          state_d  = last_q ? S_ODD : S_FLUSH;
        end
      end
      S_ODD: begin
        if (stat_i.room) begin
          if (stat_i.held_valid) begin
            cmd_o.op = OP_ODD;
          end
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        if (stat_i.room) begin
          cmd_o.op = OP_TERM;
          state_d  = S_ZFILL;
        end
      end
      S_ZFILL: begin
        if (stat_i.room) begin
          cmd_o.op = OP_ZFILL;
          state_d  = S_PAD;
        end
      end
      S_PAD: begin
        if (stat_i.room) begin
          if (stat_i.pad_fits) begin
            cmd_o.op = OP_PAD;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (stat_i.hold_empty && stat_i.room) begin
          if (last_q) begin
            cmd_o.op = OP_END;
            in_msg_d = 1'b0;
          end
          state_d = S_IDLE;
        end else begin
          cmd_o.op = OP_FLUSH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_msg_q   <= 1'b0;
      has_char_q <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_msg_q   <= in_msg_d;
      has_char_q <= has_char_d;
      last_q     <= last_d;
    end
  end

endmodule

@@ sv/qra_dp.sv @@
// ----------------------------------------------------------------------------
// qra_dp
// Datapath: bit accumulator with capacity clipping, byte hold and output stage.
// ----------------------------------------------------------------------------
module qra_dp #(
  parameter int unsigned COUNT_BITS        = 9,
  parameter int unsigned EMIT_W            = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qra_pkg::qra_cmd_t           cmd_i,
  output qra_pkg::qra_stat_t          stat_o,
  input  logic [qra_pkg::CODE_W-1:0]  char_code_i,
  input  logic [qra_pkg::COUNT_W-1:0] char_count_i,
  input  logic [EMIT_W-1:0]           cap_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  codeword_o,
  output logic                        last_codeword_o,
  output logic                        overflow_o
);
  import qra_pkg::*;

  localparam int unsigned CHUNK_W = MODE_BITS + COUNT_BITS;
  localparam int unsigned ACC_W   = CHUNK_W + 7;
  localparam int unsigned FILL_W  = $clog2(ACC_W + 1);
  localparam int unsigned N_W     = $clog2(CHUNK_W + 1);

  logic [CODE_W-1:0]     code_q;
  logic [COUNT_W-1:0]    count_q;
  logic [VALUE_W-1:0]    held_q;
  logic                  held_v_q;
  logic [ACC_W-1:0]      acc_q;
  logic [FILL_W-1:0]     fill_q;
  logic [EMIT_W-1:0]     emitted_q;
  logic                  ovf_q;
  logic                  byte_ovf_q;
  logic                  pad_sel_q;
  logic [7:0]            hold_q;
  logic                  hold_ovf_q;
  logic                  hold_v_q;
  logic                  out_valid_q;
  logic [7:0]            out_byte_q;
  logic                  out_last_q;
  logic                  out_ovf_q;

  logic [VALUE_W-1:0]    cur_value;
  logic [PAIR_BITS-1:0]  pair_value;
  logic [CHUNK_W-1:0]    app_val;
  logic [N_W-1:0]        app_n;
  logic                  app_lim;
  logic                  app_drop;
  logic                  app_en;
  logic [EMIT_W-1:0]     room;
  logic [N_W-1:0]        room_n;
  logic [N_W-1:0]        take;
  logic [ACC_W-1:0]      acc_app;
  logic                  dropped;
  logic                  fill_ge8;
  logic [7:0]            drain_byte;
  logic                  out_free;
  logic                  drain_go;
  logic                  flush_go;
  logic                  push_out;

  assign cur_value  = char_value(code_q);
  assign pair_value = PAIR_BITS'(held_q) * CHARSET_SIZE + PAIR_BITS'(cur_value);

  // append source selection
  always_comb begin
    app_val  = '0;
    app_n    = '0;
    app_lim  = 1'b1;
    app_drop = 1'b0;
    app_en   = 1'b0;
    unique case (cmd_i.op)
      OP_HDR: begin
        app_val  = {MODE_ALNUM, COUNT_BITS'(count_q)};
        app_n    = N_W'(CHUNK_W);
        app_drop = 1'b1;
        app_en   = 1'b1;
      end
      OP_CHAR: begin
        app_val  = CHUNK_W'(pair_value);
        app_n    = N_W'(PAIR_BITS);
        app_drop = 1'b1;
        app_en   = held_v_q;
      end
      OP_ODD: begin
        app_val  = CHUNK_W'(held_q);
        app_n    = N_W'(VALUE_W);
        app_drop = 1'b1;
        app_en   = 1'b1;
      end
      OP_TERM: begin
        app_n  = N_W'(TERM_BITS);
        app_en = 1'b1;
      end
      OP_ZFILL: begin
        app_n   = N_W'(3'(3'd0 - fill_q[2:0]));
        app_lim = 1'b0;
        app_en  = 1'b1;
      end
      OP_PAD: begin
        app_val = CHUNK_W'(pad_sel_q ? PAD_SECOND : PAD_FIRST);
        app_n   = N_W'(8);
        app_lim = 1'b0;
        app_en  = 1'b1;
      end
      default: ;
    endcase
  end

  // clip the chunk to the bits left below capacity; zero fill and pad bytes are not clipped
  assign room    = (emitted_q < cap_i) ? (cap_i - emitted_q) : '0;
  assign room_n  = (room > EMIT_W'(CHUNK_W)) ? N_W'(CHUNK_W) : N_W'(room);
  assign take    = (app_lim && (room_n < app_n)) ? room_n : app_n;
  assign acc_app = (acc_q << take) | (ACC_W'(app_val) >> (app_n - take));
  assign dropped = app_drop && (take != app_n);

  assign fill_ge8   = (fill_q >= FILL_W'(8));
  assign drain_byte = 8'(acc_q >> (fill_q - FILL_W'(8)));
  assign out_free   = !out_valid_q || out_ready_i;
  assign drain_go   = fill_ge8 && !app_en && (!hold_v_q || out_free);
  assign flush_go   = (cmd_i.op == OP_FLUSH) && !fill_ge8 && hold_v_q && out_free;
  assign push_out   = (drain_go && hold_v_q) || flush_go;

  assign stat_o.room       = !fill_ge8;
  assign stat_o.hold_empty = !hold_v_q;
  assign stat_o.held_valid = held_v_q;
  assign stat_o.pad_fits   = ((EMIT_W + 1)'(emitted_q) + (EMIT_W + 1)'(8))
                             <= (EMIT_W + 1)'(cap_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q      <= '0;
      count_q     <= '0;
      held_q      <= '0;
      held_v_q    <= 1'b0;
      acc_q       <= '0;
      fill_q      <= '0;
      emitted_q   <= '0;
      ovf_q       <= 1'b0;
      byte_ovf_q  <= 1'b0;
      pad_sel_q   <= 1'b0;
      hold_q      <= '0;
      hold_ovf_q  <= 1'b0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.op == OP_LOAD) begin
        code_q  <= char_code_i;
        count_q <= char_count_i;
      end

      // unpaired character
      if (cmd_i.op == OP_CHAR) begin
        if (held_v_q) begin
          held_q   <= '0;
          held_v_q <= 1'b0;
        end else begin
          held_q   <= cur_value;
          held_v_q <= 1'b1;
        end
      end else if (cmd_i.op == OP_ODD) begin
        held_q   <= '0;
        held_v_q <= 1'b0;
      end

      if (cmd_i.op == OP_PAD) begin
        pad_sel_q <= !pad_sel_q;
      end

      // accumulator: clear at message end, append a chunk or shift out one byte
      if (cmd_i.op == OP_END) begin
        acc_q      <= '0;
        fill_q     <= '0;
        emitted_q  <= '0;
        ovf_q      <= 1'b0;
        byte_ovf_q <= 1'b0;
        pad_sel_q  <= 1'b0;
      end else if (app_en) begin
        acc_q      <= acc_app;
        fill_q     <= fill_q + FILL_W'(take);
        emitted_q  <= emitted_q + EMIT_W'(take);
        byte_ovf_q <= ovf_q;
        ovf_q      <= ovf_q | dropped;
      end else if (drain_go) begin
        fill_q <= fill_q - FILL_W'(8);
      end

      // hold stage keeps the newest byte until its last flag is known
      if (drain_go) begin
        hold_q     <= drain_byte;
        hold_ovf_q <= byte_ovf_q;
        hold_v_q   <= 1'b1;
      end else if (flush_go) begin
        hold_v_q <= 1'b0;
      end

      if (push_out) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= hold_q;
        out_last_q  <= flush_go && cmd_i.last;
        out_ovf_q   <= hold_ovf_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign codeword_o      = out_byte_q;
  assign last_codeword_o = out_last_q;
  assign overflow_o      = out_ovf_q;

endmodule

@@ sv/qr_alphanumeric_data_encoder_top.sv @@
// ----------------------------------------------------------------------------
// qr_alphanumeric_data_encoder_top
// QR alphanumeric-mode encoder: characters in, data codeword bytes out.
// ----------------------------------------------------------------------------
// sequence: an item that is not the last goes from acceptance through the
//   header (first item only), character and flush states until ready rises
//   again with the output free; its bytes leave via a hold stage and an output beat
// flow: one item at a time; the last item of a message also appends the
//   terminator, zero fill and pad codewords, set by the single append-or-byte-shift
//   per cycle on the bit accumulator, the shift only while the hold stage can take a byte
// reset: asynchronous, clears the sequencer and accumulator, version 1 level L
module qr_alphanumeric_data_encoder_top #(
  parameter int unsigned COUNT_BITS        = 9,
  parameter int unsigned MAX_CAPACITY_BITS = 272
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [qra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qra_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // character input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [qra_pkg::CODE_W-1:0]     char_code_i,
  input  logic [qra_pkg::COUNT_W-1:0]    char_count_i,
  input  logic                           has_char_i,
  input  logic                           last_i,
  // codeword output
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     codeword_o,
  output logic                           last_codeword_o,
  output logic                           overflow_o
);
  import qra_pkg::*;

  // bit counter reaches capacity plus a partial byte of zero fill
  localparam int unsigned EMIT_W = $clog2(MAX_CAPACITY_BITS + 8);

  logic [1:0]           version_q;
  logic [2:0]           level_q;
  logic                 cap_row;
  logic [1:0]           cap_col;
  logic [CAP_TBL_W-1:0] cap_tbl;
  logic [EMIT_W-1:0]    cap;
  qra_cmd_t             cmd;
  qra_stat_t            stat;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= 2'd1;
      level_q   <= 3'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_VERSION: version_q <= cfg_data_i[1:0];
        CFG_LEVEL:   level_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // version 0 acts as 1 and 3 as 2; level 0 acts as L and 5..7 as H
  assign cap_row = version_q[1];

  always_comb begin
    if (level_q == 3'd0) begin
      cap_col = 2'd0;
    end else if (level_q >= 3'd4) begin
      cap_col = 2'd3;
    end else begin
      cap_col = 2'(level_q - 3'd1);
    end
  end

  assign cap_tbl = cap_lookup(cap_row, cap_col);
  // capacity also bounded by the build-time maximum
  assign cap = (int'(cap_tbl) > int'(MAX_CAPACITY_BITS)) ? EMIT_W'(MAX_CAPACITY_BITS)
                                                          : EMIT_W'(cap_tbl);

  // sequencer
  qra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .has_char_i (has_char_i),
    .last_i     (last_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // bit packing and byte output
  qra_dp #(
    .COUNT_BITS        (COUNT_BITS),
    .EMIT_W            (EMIT_W)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .char_code_i     (char_code_i),
    .char_count_i    (char_count_i),
    .cap_i           (cap),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .codeword_o      (codeword_o),
    .last_codeword_o (last_codeword_o),
    .overflow_o      (overflow_o)
  );

endmodule
